/* rtl/sdd_pkg.sv */
// Package for the stereo depth block: widths, status and register codes,
// and the structs that travel down the divider pipeline. No dependencies.
package sdd_pkg;

   localparam int COORD_FRAC_BITS_DEF = 4;

   localparam int FB_W      = 24;
   localparam int DEPTH_W   = 16;
   localparam int COORD_W   = 16;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   // quotient bits are resolved a few per stage
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = DEPTH_W / DIV_STAGES;

   localparam logic [STAT_W-1:0] ST_VALID    = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_DEPTH = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_BASELINE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH      = 2'd2;

   localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 16'hFFFF;

   typedef struct packed {
      logic [STAT_W-1:0] status;  // final status when bypass is set
      logic              bypass;  // result does not come from the quotient
      logic              ovf;     // quotient exceeds the depth range
   } meta_type;

   typedef struct packed {
      logic [COORD_W-1:0] rem;    // partial remainder, below disp for in-range divisions
      logic [DEPTH_W-1:0] nq;     // dividend bits shifting out, quotient shifting in
      logic [COORD_W-1:0] disp;   // divisor
   } div_type;

endpackage

/* rtl/sdd_if.sv */
// Channel interfaces of the stereo depth block: keypoint pair in, depth out,
// register writes. Depends on sdd_pkg.
interface sdd_req_if import sdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  left_status;
   logic [STAT_W-1:0]  right_status;
   logic [COORD_W-1:0] left_x;
   logic [COORD_W-1:0] right_x;

   modport source (output valid, left_status, right_status, left_x, right_x, input ready);
   modport sink   (input valid, left_status, right_status, left_x, right_x, output ready);
endinterface

interface sdd_rsp_if import sdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_mm;
   logic [STAT_W-1:0]  new_right_status;

   modport source (output valid, depth_mm, new_right_status, input ready);
   modport sink   (input valid, depth_mm, new_right_status, output ready);
endinterface

interface sdd_csr_if import sdd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/stereo_depth_from_disparity_top.sv */
// Stereo depth from disparity: one keypoint pair in, one depth result out.
// Pipeline: six register stages (front stage, four divider stages of four quotient
// bits each, output register).
// Throughput: one pair per cycle unless rsp_ch stalls; set by the pipelined divider.
// Reset: synchronous, clears all valid bits and loads the register defaults.
module stereo_depth_from_disparity_top import sdd_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sdd_req_if.sink   req_ch,
   sdd_rsp_if.source rsp_ch,
   sdd_csr_if.sink   csr_ch
);

   logic [FB_W-1:0]    focal_baseline_ff;
   logic [DEPTH_W-1:0] min_depth_ff;
   logic [DEPTH_W-1:0] max_depth_ff;

   logic     pipe_valid [DIV_STAGES+1];
   logic     pipe_ready [DIV_STAGES+1];
   meta_type pipe_meta  [DIV_STAGES+1];
   div_type  pipe_div   [DIV_STAGES+1];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_baseline_ff <= '0;
         min_depth_ff      <= '0;
         max_depth_ff      <= MAX_DEPTH_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_FOCAL_BASELINE: focal_baseline_ff <= csr_ch.data[FB_W-1:0];
            CSR_MIN_DEPTH:      min_depth_ff      <= csr_ch.data[DEPTH_W-1:0];
            CSR_MAX_DEPTH:      max_depth_ff      <= csr_ch.data[DEPTH_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   sdd_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .focal_baseline (focal_baseline_ff),
      .out_valid      (pipe_valid[0]),
      .out_ready      (pipe_ready[0]),
      .out_meta       (pipe_meta[0]),
      .out_div        (pipe_div[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      sdd_div_stage #(
         .STEPS(DIV_STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[s]),
         .in_ready  (pipe_ready[s]),
         .in_meta   (pipe_meta[s]),
         .in_div    (pipe_div[s]),
         .out_valid (pipe_valid[s+1]),
         .out_ready (pipe_ready[s+1]),
         .out_meta  (pipe_meta[s+1]),
         .out_div   (pipe_div[s+1])
      );
   end

   sdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_valid[DIV_STAGES]),
      .in_ready  (pipe_ready[DIV_STAGES]),
      .in_meta   (pipe_meta[DIV_STAGES]),
      .in_quot   (pipe_div[DIV_STAGES].nq),
      .min_depth (min_depth_ff),
      .max_depth (max_depth_ff),
      .rsp       (rsp_ch)
   );

endmodule

/* rtl/sdd_front.sv */
// Front stage: status decode, disparity, range pre-check and divider setup.
// Depends on sdd_pkg and sdd_if.
module sdd_front import sdd_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   sdd_req_if.sink         req,
   input  logic [FB_W-1:0] focal_baseline,
   output logic            out_valid,
   input  logic            out_ready,
   output meta_type        out_meta,
   output div_type         out_div
);

   localparam int NUM_W = FB_W + COORD_FRAC_BITS;
   localparam int UP_W  = NUM_W - DEPTH_W;

   logic [NUM_W-1:0]   num;
   logic [UP_W-1:0]    upper;
   logic [COORD_W-1:0] disp;
   logic               ovf;
   meta_type           meta_in;
   div_type            div_in;
   logic               valid_ff;
   meta_type           meta_ff;
   div_type            div_ff;
   logic               take;

   always_comb begin
      num   = NUM_W'(focal_baseline) << COORD_FRAC_BITS;
      upper = num[NUM_W-1:DEPTH_W];
      disp  = req.left_x - req.right_x;
      // quotient above the 16-bit range exactly when the high part reaches the divisor
      ovf   = COORD_W'(upper) >= disp;

      meta_in.ovf = ovf;
      if (req.left_status != ST_VALID) begin
         meta_in.status = req.left_status;
         meta_in.bypass = 1'b1;
      end else if (req.right_status != ST_VALID) begin
         meta_in.status = req.right_status;
         meta_in.bypass = 1'b1;
      end else if (req.left_x <= req.right_x) begin
         meta_in.status = ST_NO_DEPTH;
         meta_in.bypass = 1'b1;
      end else begin
         meta_in.status = ST_VALID;
         meta_in.bypass = 1'b0;
      end

      div_in.rem  = ovf ? '0 : COORD_W'(upper);
      div_in.nq   = num[DEPTH_W-1:0];
      div_in.disp = disp;
   end

   assign req.ready = !valid_ff || out_ready;
   assign take      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         meta_ff <= meta_in;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_div   = div_ff;

   // an item sent to the divider has a positive disparity
   a_disp_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !meta_ff.bypass |-> div_ff.disp != '0)
      else $error("divider item with zero disparity");

   // only a pair with both statuses valid skips the bypass
   a_status_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !meta_ff.bypass |-> meta_ff.status == ST_VALID)
      else $error("divider item without valid status");

endmodule

/* rtl/sdd_div_stage.sv */
// One stage of the restoring divider: resolves STEPS quotient bits.
// Depends on sdd_pkg.
module sdd_div_stage import sdd_pkg::*; #(
   parameter int STEPS = DIV_STEPS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  meta_type in_meta,
   input  div_type  in_div,
   output logic     out_valid,
   input  logic     out_ready,
   output meta_type out_meta,
   output div_type  out_div
);

   logic [COORD_W:0] part;
   logic             qbit;
   div_type          div_in;
   logic             valid_ff;
   meta_type         meta_ff;
   div_type          div_ff;

   always_comb begin
      div_in = in_div;
      part   = '0;
      qbit   = 1'b0;
      for (int i = 0; i < STEPS; i++) begin
         part = {div_in.rem, div_in.nq[DEPTH_W-1]};
         qbit = part >= {1'b0, div_in.disp};
         if (qbit) begin
            part = part - {1'b0, div_in.disp};
         end
         div_in.rem = part[COORD_W-1:0];
         div_in.nq  = {div_in.nq[DEPTH_W-2:0], qbit};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         meta_ff <= in_meta;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_div   = div_ff;

   // remainder stays below the divisor for in-range divisions
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !meta_ff.bypass && !meta_ff.ovf |-> div_ff.rem < div_ff.disp)
      else $error("divider remainder out of bound");

   // divisor travels unchanged through the stage
   a_disp_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> div_ff.disp == $past(in_div.disp))
      else $error("divisor changed in stage");

endmodule

/* rtl/sdd_back.sv */
// Back stage: depth range check, status select and the output register.
// Depends on sdd_pkg and sdd_if.
module sdd_back import sdd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  meta_type           in_meta,
   input  logic [DEPTH_W-1:0] in_quot,
   input  logic [DEPTH_W-1:0] min_depth,
   input  logic [DEPTH_W-1:0] max_depth,
   sdd_rsp_if.source          rsp
);

   logic [DEPTH_W-1:0] depth_in;
   logic [STAT_W-1:0]  status_in;
   logic               valid_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [STAT_W-1:0]  status_ff;

   always_comb begin
      if (in_meta.bypass) begin
         depth_in  = '0;
         status_in = in_meta.status;
      end else if (in_meta.ovf || in_quot < min_depth || in_quot > max_depth) begin
         depth_in  = '0;
         status_in = ST_NO_DEPTH;
      end else begin
         depth_in  = in_quot;
         status_in = ST_VALID;
      end
   end

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         depth_ff  <= depth_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.depth_mm         = depth_ff;
   assign rsp.new_right_status = status_ff;

   // any status other than valid carries a zero depth
   a_depth_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != ST_VALID |-> depth_ff == '0)
      else $error("invalid status with nonzero depth");

endmodule

/* tb/tb_stereo_depth_from_disparity_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for stereo_depth_from_disparity_top: a directed table
// and random keypoint pairs, checked against table results or a bench depth predictor.
// Depends on sdd_pkg and the channel interfaces in sdd_if.sv.
module tb_stereo_depth_from_disparity_top;
   import sdd_pkg::*;

   localparam int          COORD_FRAC   = COORD_FRAC_BITS_DEF;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          TAIL_CYCLES  = 16;
   localparam int          RANDOM_SETS  = 12;
   localparam int          PAIRS_PER_SET = 152;
   localparam int          PRINT_LIMIT  = 40;

   // status codes the package leaves out
   localparam logic [STAT_W-1:0] ST_NO_LEFT_RECT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_RIGHT_RECT = 3'd2;
   localparam logic [STAT_W-1:0] ST_FAILED_ARUN   = 3'd4;
   localparam logic [STAT_W-1:0] ST_RSVD_LO       = 3'd5;
   localparam logic [STAT_W-1:0] ST_RSVD_HI       = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0]  left_status;
      logic [STAT_W-1:0]  right_status;
      logic [COORD_W-1:0] left_x;
      logic [COORD_W-1:0] right_x;
   } keypoint_pair_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [STAT_W-1:0]  status;
   } depth_result_type;

   typedef enum logic {ROW_PAIR, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      keypoint_pair_type    pair;
      logic                 typed;
      depth_result_type     result;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CSR_DAT_W-1:0] csr_data;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   sdd_req_if req_bus();
   sdd_rsp_if rsp_bus();
   sdd_csr_if csr_bus();

   stereo_depth_from_disparity_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // register copies seen by the predictor
   logic [FB_W-1:0]    focal_cfg;
   logic [DEPTH_W-1:0] min_cfg;
   logic [DEPTH_W-1:0] max_cfg;

   depth_result_type depth_queue[$];
   stim_row_type     directed_rows[$];
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      cycle_count;
   int unsigned      error_count;
   int unsigned      pair_count;
   int unsigned      result_count;
   int unsigned      valid_depth_count;
   int unsigned      csr_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic depth_result_type predict_depth(input keypoint_pair_type p);
      logic [COORD_W-1:0]         disp;
      logic [FB_W+COORD_FRAC-1:0] dividend;
      logic [FB_W+COORD_FRAC-1:0] quot;
      depth_result_type           r;
      r.depth = '0;
      if (p.left_status != ST_VALID) begin
         r.status = p.left_status;
      end else if (p.right_status != ST_VALID) begin
         r.status = p.right_status;
      end else if (p.left_x <= p.right_x) begin
         // zero disparity is the infinite-depth case
         r.status = ST_NO_DEPTH;
      end else begin
         disp     = p.left_x - p.right_x;
         dividend = {focal_cfg, {COORD_FRAC{1'b0}}};
         quot     = dividend / disp;
         if (quot < min_cfg || quot > max_cfg) begin
            r.status = ST_NO_DEPTH;
         end else begin
            r.status = ST_VALID;
            r.depth  = quot[DEPTH_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic keypoint_pair_type random_pair();
      keypoint_pair_type          p;
      int unsigned                pick;
      int unsigned                disp;
      int unsigned                tgt;
      logic [FB_W+COORD_FRAC-1:0] dividend;
      pick           = $urandom_range(99);
      p.left_status  = ST_VALID;
      p.right_status = ST_VALID;
      p.left_x       = COORD_W'($urandom);
      p.right_x      = COORD_W'($urandom);
      if (pick < 8) begin
         p.left_status  = STAT_W'($urandom_range(ST_NO_LEFT_RECT, ST_RSVD_HI));
         p.right_status = STAT_W'($urandom_range(ST_VALID, ST_RSVD_HI));
      end else if (pick < 16) begin
         p.right_status = STAT_W'($urandom_range(ST_NO_LEFT_RECT, ST_RSVD_HI));
      end else if (pick < 20) begin
         p.left_x = p.right_x;
      end else if (pick < 26) begin
         p.left_x = COORD_W'($urandom_range(0, p.right_x));
      end else begin
         case ($urandom_range(2))
            0: disp = $urandom_range(1, 65535);
            1: disp = $urandom_range(1, 255);
            default: begin
               // aim the quotient into the accepted window, or just past an edge
               if (min_cfg <= max_cfg)
                  tgt = $urandom_range(min_cfg, max_cfg);
               else
                  tgt = $urandom_range(0, 65535);
               dividend = {focal_cfg, {COORD_FRAC{1'b0}}};
               disp = (tgt == 0) ? 65535 : dividend / tgt;
               if ($urandom_range(1))
                  disp = disp + 1;
               if (disp == 0)
                  disp = 1;
               if (disp > 65535)
                  disp = 65535;
            end
         endcase
         p.right_x = COORD_W'($urandom_range(0, 65535 - disp));
         p.left_x  = COORD_W'(p.right_x + disp);
      end
      return p;
   endfunction

   function automatic stim_row_type pair_row(input logic [STAT_W-1:0] ls, rs,
                                             input logic [COORD_W-1:0] lx, rx);
      stim_row_type row;
      row.kind     = ROW_PAIR;
      row.pair     = '{ls, rs, lx, rx};
      row.typed    = 1'b0;
      row.result   = '0;
      row.csr_idx  = '0;
      row.csr_data = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic [STAT_W-1:0] ls, rs,
                                              input logic [COORD_W-1:0] lx, rx,
                                              input logic [DEPTH_W-1:0] depth,
                                              input logic [STAT_W-1:0] status);
      stim_row_type row;
      row        = pair_row(ls, rs, lx, rx);
      row.typed  = 1'b1;
      row.result = '{depth, status};
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DAT_W-1:0] data);
      stim_row_type row;
      row          = pair_row(ST_VALID, ST_VALID, '0, '0);
      row.kind     = ROW_CSR;
      row.csr_idx  = idx;
      row.csr_data = data;
      return row;
   endfunction

   // append a row at the end of the directed table
   function automatic void add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // hold valid high across back-to-back transfers; drop it only to idle
   task automatic send_pair(input keypoint_pair_type p, input logic typed,
                            input depth_result_type typed_result);
      if (csr_bus.valid)
         csr_bus.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.left_status  <= p.left_status;
      req_bus.right_status <= p.right_status;
      req_bus.left_x       <= p.left_x;
      req_bus.right_x      <= p.right_x;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      depth_queue.insert(depth_queue.size(), typed ? typed_result : predict_depth(p));
      pair_count++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      case (idx)
         CSR_FOCAL_BASELINE: focal_cfg = data[FB_W-1:0];
         CSR_MIN_DEPTH:      min_cfg   = data[DEPTH_W-1:0];
         CSR_MAX_DEPTH:      max_cfg   = data[DEPTH_W-1:0];
         default: ;
      endcase
      csr_count++;
   endtask

   // every pair yields a result, so an empty queue means the pipe is idle
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (depth_queue.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      depth_result_type exp_result;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (depth_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result depth %0d status %0d",
                                         rsp_bus.depth_mm, rsp_bus.new_right_status));
            end else begin
               exp_result = depth_queue.pop_front();
               if (exp_result.status == ST_VALID)
                  valid_depth_count++;
               if (rsp_bus.depth_mm !== exp_result.depth)
                  report_mismatch($sformatf("depth_mm %0d, expected %0d",
                                            rsp_bus.depth_mm, exp_result.depth));
               if (rsp_bus.new_right_status !== exp_result.status)
                  report_mismatch($sformatf("new_right_status %0d, expected %0d",
                                            rsp_bus.new_right_status, exp_result.status));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      logic [FB_W-1:0]    fb;
      logic [DEPTH_W-1:0] lo;
      logic [DEPTH_W-1:0] hi;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.left_status  = '0;
      req_bus.right_status = '0;
      req_bus.left_x       = '0;
      req_bus.right_x      = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      focal_cfg            = '0;
      min_cfg              = '0;
      max_cfg              = MAX_DEPTH_RST;
      send_idle_pct        = 26;
      recv_idle_pct        = 59;

      // register defaults: zero focal_baseline gives a zero depth that is accepted
      add_row(typed_row(ST_VALID, ST_VALID, 16'd16, 16'd0, '0, ST_VALID));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd0, 16'd0, '0, ST_NO_DEPTH));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd0, 16'hFFFF, '0, ST_NO_DEPTH));
      add_row(typed_row(ST_NO_LEFT_RECT, ST_VALID, 16'hFFFF, 16'd0, '0, ST_NO_LEFT_RECT));
      add_row(typed_row(ST_FAILED_ARUN, ST_NO_RIGHT_RECT, 16'd5, 16'd1, '0,
                        ST_FAILED_ARUN));
      add_row(typed_row(ST_VALID, ST_NO_DEPTH, 16'hFFFF, 16'd0, '0, ST_NO_DEPTH));
      add_row(typed_row(ST_RSVD_HI, ST_RSVD_LO, 16'd9, 16'd3, '0, ST_RSVD_HI));
      add_row(typed_row(ST_VALID, ST_RSVD_LO, 16'd9, 16'd3, '0, ST_RSVD_LO));
      // largest focal_baseline: widest and narrowest disparity
      add_row(csr_row(CSR_FOCAL_BASELINE, 24'hFFFFFF));
      add_row(pair_row(ST_VALID, ST_VALID, 16'hFFFF, 16'd0));
      add_row(typed_row(ST_VALID, ST_VALID, 16'hFFFF, 16'hFFFE, '0, ST_NO_DEPTH));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd1, 16'd0, '0, ST_NO_DEPTH));
      add_row(pair_row(ST_VALID, ST_VALID, 16'h8000, 16'd0));
      // upper data bits are dropped for the depth limits; quotient sits on max
      add_row(csr_row(CSR_MIN_DEPTH, 24'hFF03E8));
      add_row(csr_row(CSR_MAX_DEPTH, 24'hA51000));
      add_row(pair_row(ST_VALID, ST_VALID, 16'hFFFF, 16'd0));
      add_row(csr_row(CSR_MIN_DEPTH, 24'h001001));
      add_row(pair_row(ST_VALID, ST_VALID, 16'hFFFF, 16'd0));
      // min above max rejects everything; a write past the list changes nothing
      add_row(csr_row(CSR_MIN_DEPTH, 24'h00FFFF));
      add_row(csr_row(CSR_MAX_DEPTH, 24'hFF0000));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd200, 16'd100, '0, ST_NO_DEPTH));
      add_row(csr_row(CSR_UNUSED, 24'hFFFFFF));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd200, 16'd100, '0, ST_NO_DEPTH));
      // zero focal_baseline against a zero and a nonzero lower limit
      add_row(csr_row(CSR_FOCAL_BASELINE, 24'h000000));
      add_row(csr_row(CSR_MIN_DEPTH, 24'h000000));
      add_row(csr_row(CSR_MAX_DEPTH, 24'h000000));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd100, 16'd50, '0, ST_VALID));
      add_row(csr_row(CSR_MIN_DEPTH, 24'h000001));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd100, 16'd50, '0, ST_NO_DEPTH));
      add_row(csr_row(CSR_FOCAL_BASELINE, 24'h000001));
      add_row(csr_row(CSR_MIN_DEPTH, 24'h000000));
      add_row(csr_row(CSR_MAX_DEPTH, 24'h00FFFF));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd16, 16'd0, 16'd1, ST_VALID));
      add_row(pair_row(ST_VALID, ST_VALID, 16'd17, 16'd0));
      // quotient of exactly 65535, then one past the output width
      add_row(csr_row(CSR_FOCAL_BASELINE, 24'h0FFFFF));
      add_row(pair_row(ST_VALID, ST_VALID, 16'd256, 16'd0));
      add_row(typed_row(ST_VALID, ST_VALID, 16'd255, 16'd0, '0, ST_NO_DEPTH));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_results_drained();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_data);
         end else begin
            send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].result);
         end
      end

      for (int set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
         case (set_idx / (RANDOM_SETS / 3))
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 59;
            end
            1: begin
               send_idle_pct = 59;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case ($urandom_range(3))
            0: fb = FB_W'($urandom_range(1, 4095));
            1: begin
               fb = FB_W'($urandom);
               fb = fb >> $urandom_range(0, FB_W - 1);
            end
            2: fb = FB_W'($urandom);
            default: fb = $urandom_range(1) ? '1 : '0;
         endcase
         case ($urandom_range(4))
            0: begin
               lo = '0;
               hi = '1;
            end
            1: begin
               lo = DEPTH_W'($urandom_range(0, 2000));
               hi = DEPTH_W'($urandom_range(lo, 65535));
            end
            2: begin
               lo = DEPTH_W'($urandom);
               hi = lo;
            end
            3: begin
               lo = DEPTH_W'($urandom_range(1, 65535));
               hi = DEPTH_W'($urandom_range(0, lo - 1));
            end
            default: begin
               lo = DEPTH_W'($urandom_range(0, 30000));
               hi = DEPTH_W'($urandom_range(lo, 65535));
            end
         endcase
         wait_results_drained();
         write_csr(CSR_FOCAL_BASELINE, fb);
         write_csr(CSR_MIN_DEPTH, {8'($urandom), lo});
         write_csr(CSR_MAX_DEPTH, {8'($urandom), hi});
         for (int n = 0; n < PAIRS_PER_SET; n++)
            send_pair(random_pair(), 1'b0, '0);
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d keypoint pairs and %0d register writes over %0d settings.",
               pair_count, csr_count, RANDOM_SETS + 1);
      $display("Checked %0d results, %0d of them with an accepted depth; %0d mismatches.",
               result_count, valid_depth_count, error_count);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
